@@ src/rssi_average_percent_defines.svh @@
// Assertion macros shared by the signal-strength meter.
// Standalone header; the files that check themselves include it.
`ifndef RSSI_AVERAGE_PERCENT_DEFINES_SVH
`define RSSI_AVERAGE_PERCENT_DEFINES_SVH

// Same-cycle implication, sampled on clk and quiet while rst is high.
`define RSSIAP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and quiet while rst is high.
`define RSSIAP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/rssiap_pkg.sv @@
// Shared types and constants of the signal-strength meter.
// No dependencies; the controller, datapath and top level refer to it by scoped names.
`timescale 1ns / 1ps

package rssiap_pkg;

  localparam int FILTER_DEPTH_DEF = 4;
  localparam int SAMPLE_BITS_DEF  = 12;

  // Percentage format: unsigned Q7.8
  localparam int PCT_W = 15;
  localparam logic [PCT_W-1:0] PCT_LIMIT_Q8 = 15'd25344;
  localparam int PCT_SCALE = 25600;  // 100 in Q8
  localparam int SAT_LHS   = 100;
  localparam int SAT_RHS   = 99;

  // Configuration register indexes
  localparam int CFG_INDEX_BITS = 2;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_MIN_RX0 = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_MAX_RX0 = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_MIN_RX1 = 2'd2;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_MAX_RX1 = 2'd3;

  typedef struct packed {
    logic capture;   // latch the incoming word
    logic update;    // write ring, update sum
    logic mean;      // take the truncated mean of the ring
    logic div_step;  // one divider iteration
    logic scale;     // form offset and span from the mean
    logic mult;      // form scaled numerator and saturation terms
    logic load_pct;  // load divider for the percentage
    logic set_zero;  // result is zero
    logic set_sat;   // result saturates
    logic load_out;  // fill the output register
  } cmd_t;

  typedef struct packed {
    logic div_last;
    logic zero_case;
    logic sat_case;
    logic out_free;
  } status_t;

endpackage

@@ src/rssiap_div.sv @@
// Restoring divider, one quotient bit per cycle while step is high.
// Uses rssiap_pkg for nothing; stands alone.
`timescale 1ns / 1ps

module rssiap_div #(
  parameter int REM_W = 12,
  parameter int QW    = 15,
  parameter int CNT_W = $clog2(QW + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  logic             step,
  input  logic [REM_W-1:0] rem_init,
  input  logic [QW-1:0]    num_init,
  input  logic [REM_W-1:0] den,
  input  logic [CNT_W-1:0] iters,
  output logic [QW-1:0]    quot,
  output logic             last
);

  logic [REM_W-1:0] rem;
  logic [QW-1:0]    num;
  logic [REM_W-1:0] divisor;
  logic [CNT_W-1:0] cnt;
  logic [REM_W:0]   trial;
  logic             qbit;

  assign trial = {rem, num[QW-1]} - {1'b0, divisor};
  assign qbit  = ~trial[REM_W];
  assign last  = (cnt == CNT_W'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (load) begin
      cnt <= iters;
    end else if (step && cnt != '0) begin
      cnt <= cnt - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rem     <= rem_init;
      num     <= num_init;
      divisor <= den;
      quot    <= '0;
    end else if (step) begin
      rem  <= qbit ? trial[REM_W-1:0] : {rem[REM_W-2:0], num[QW-1]};
      num  <= {num[QW-2:0], 1'b0};
      quot <= {quot[QW-2:0], qbit};
    end
  end

endmodule

@@ src/rssiap_datapath.sv @@
// Datapath: calibration registers, sample rings, running sums, scaling and output register.
// Depends on rssiap_pkg and rssiap_div.
`timescale 1ns / 1ps

module rssiap_datapath #(
  parameter int FILTER_DEPTH = rssiap_pkg::FILTER_DEPTH_DEF,
  parameter int SAMPLE_BITS  = rssiap_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  rssiap_pkg::cmd_t                    cmd,
  output rssiap_pkg::status_t                 status,
  input  logic                                cfg_we,
  input  logic [rssiap_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [SAMPLE_BITS-1:0]              cfg_data,
  input  logic [SAMPLE_BITS-1:0]              level_sample,
  input  logic                                receiver_sel,
  input  logic                                out_ready,
  output logic                                out_valid,
  output logic [rssiap_pkg::PCT_W-1:0]        percent_q8,
  output logic [SAMPLE_BITS-1:0]              filtered_level,
  output logic                                receiver_tag
);

  localparam int SB      = SAMPLE_BITS;
  localparam int PW      = rssiap_pkg::PCT_W;
  localparam int SLOT_W  = $clog2(FILTER_DEPTH);
  localparam int SUM_W   = SB + SLOT_W;
  localparam int NUM_W   = SB + PW;
  localparam int PROD_W  = SB + 7;
  localparam int CNT_W   = $clog2(PW + 1);
  // Mean by reciprocal multiplication, exact for every sum below 2**SUM_W
  localparam int MEAN_SH = SUM_W + SLOT_W;
  localparam int RECIP   = ((1 << MEAN_SH) + FILTER_DEPTH - 1) / FILTER_DEPTH;
  localparam int MPROD_W = 2 * SUM_W + 1;

  // Calibration
  logic [SB-1:0] cal_min_rx0, cal_max_rx0, cal_min_rx1, cal_max_rx1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cal_min_rx0 <= '0;
      cal_max_rx0 <= '1;
      cal_min_rx1 <= '0;
      cal_max_rx1 <= '1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rssiap_pkg::CFG_MIN_RX0: cal_min_rx0 <= cfg_data;
        rssiap_pkg::CFG_MAX_RX0: cal_max_rx0 <= cfg_data;
        rssiap_pkg::CFG_MIN_RX1: cal_min_rx1 <= cfg_data;
        rssiap_pkg::CFG_MAX_RX1: cal_max_rx1 <= cfg_data;
        default: ;
      endcase
    end
  end

  // Captured word
  logic [SB-1:0] sample_r;
  logic          sel_r;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      sample_r <= level_sample;
      sel_r    <= receiver_sel;
    end
  end

  logic [SB-1:0] lo, hi;
  assign lo = sel_r ? cal_min_rx1 : cal_min_rx0;
  assign hi = sel_r ? cal_max_rx1 : cal_max_rx0;

  // Rings and running sums
  logic [SB-1:0]     ring [2][FILTER_DEPTH];
  logic [SLOT_W-1:0] slot [2];
  logic [SUM_W-1:0]  sums [2];
  logic [SB-1:0]     oldest;
  logic [SUM_W-1:0]  sum_new;

  assign oldest  = ring[sel_r][slot[sel_r]];
  assign sum_new = sums[sel_r] - SUM_W'(oldest) + SUM_W'(sample_r);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < 2; r++) begin
        slot[r] <= '0;
        sums[r] <= '0;
        for (int i = 0; i < FILTER_DEPTH; i++) begin
          ring[r][i] <= '0;
        end
      end
    end else if (cmd.update) begin
      ring[sel_r][slot[sel_r]] <= sample_r;
      sums[sel_r]              <= sum_new;
      slot[sel_r] <= (slot[sel_r] == SLOT_W'(FILTER_DEPTH - 1)) ? '0
                                                               : slot[sel_r] + SLOT_W'(1);
    end
  end

  // Mean of the updated ring
  logic [MPROD_W-1:0] mean_prod;
  assign mean_prod = MPROD_W'(sums[sel_r]) * MPROD_W'(RECIP);

  // Scaling
  logic [SB-1:0]     level, diff, span;
  logic              zero_r;
  logic [PROD_W-1:0] lhs, rhs;
  logic [NUM_W-1:0]  num;
  logic [PW-1:0]     pct_fixed;
  logic              use_div;

  // Percentage divider
  logic [PW-1:0] quot;
  logic          div_last;
  logic [SB-1:0] rem_init;
  logic [PW-1:0] num_init;

  assign rem_init = num[NUM_W-1:PW];
  assign num_init = num[PW-1:0];

  rssiap_div #(
    .REM_W (SB),
    .QW    (PW),
    .CNT_W (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .load     (cmd.load_pct),
    .step     (cmd.div_step),
    .rem_init (rem_init),
    .num_init (num_init),
    .den      (span),
    .iters    (CNT_W'(PW)),
    .quot     (quot),
    .last     (div_last)
  );

  always_ff @(posedge clk) begin
    if (cmd.mean) begin
      level <= mean_prod[MEAN_SH +: SB];
    end
    if (cmd.scale) begin
      diff   <= level - lo;
      span   <= hi - lo;
      zero_r <= (hi <= lo) || (level < lo);
    end
    if (cmd.mult) begin
      num <= NUM_W'(diff) * NUM_W'(rssiap_pkg::PCT_SCALE);
      lhs <= PROD_W'(diff) * PROD_W'(rssiap_pkg::SAT_LHS);
      rhs <= PROD_W'(span) * PROD_W'(rssiap_pkg::SAT_RHS);
    end
    if (cmd.set_zero) begin
      pct_fixed <= '0;
      use_div   <= 1'b0;
    end else if (cmd.set_sat) begin
      pct_fixed <= rssiap_pkg::PCT_LIMIT_Q8;
      use_div   <= 1'b0;
    end else if (cmd.load_pct) begin
      use_div   <= 1'b1;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      percent_q8     <= use_div ? quot : pct_fixed;
      filtered_level <= level;
      receiver_tag   <= sel_r;
    end
  end

  assign status.div_last  = div_last;
  assign status.zero_case = zero_r;
  assign status.sat_case  = (lhs >= rhs);
  assign status.out_free  = ~out_valid | out_ready;

endmodule

@@ src/rssiap_ctrl.sv @@
// Sequencer of the signal-strength meter.
// Depends on rssiap_pkg for the command and status structs.
`timescale 1ns / 1ps

module rssiap_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  rssiap_pkg::status_t status,
  output rssiap_pkg::cmd_t    cmd
);

  typedef enum logic [7:0] {
    ST_IDLE   = 8'b0000_0001,
    ST_UPDATE = 8'b0000_0010,
    ST_MEAN   = 8'b0000_0100,
    ST_SCALE  = 8'b0000_1000,
    ST_MULT   = 8'b0001_0000,
    ST_CHECK  = 8'b0010_0000,
    ST_PCT    = 8'b0100_0000,
    ST_DONE   = 8'b1000_0000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        cmd.update = 1'b1;
        state_next = ST_MEAN;
      end
      ST_MEAN: begin
        cmd.mean   = 1'b1;
        state_next = ST_SCALE;
      end
      ST_SCALE: begin
        cmd.scale  = 1'b1;
        state_next = ST_MULT;
      end
      ST_MULT: begin
        cmd.mult   = 1'b1;
        state_next = ST_CHECK;
      end
      ST_CHECK: begin
        if (status.zero_case) begin
          cmd.set_zero = 1'b1;
          state_next   = ST_DONE;
        end else if (status.sat_case) begin
          cmd.set_sat = 1'b1;
          state_next  = ST_DONE;
        end else begin
          cmd.load_pct = 1'b1;
          state_next   = ST_PCT;
        end
      end
      ST_PCT: begin
        cmd.div_step = 1'b1;
        if (status.div_last) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

@@ src/rssi_average_percent.sv @@
// Two-receiver signal-strength meter: moving average and calibrated percentage.
// Top level; depends on rssiap_pkg, rssiap_ctrl, rssiap_datapath and the defines header.
//
// Input channel (in_valid/in_ready) takes one word: level_sample and receiver_sel.
// Output channel (out_valid/out_ready) gives one word per input: percent_q8
//   (unsigned Q7.8, clamped to 99.0), filtered_level (truncated ring mean), receiver_tag.
// Configuration: cfg_we writes cfg_data into register cfg_index at that edge
//   (0 min rx0, 1 max rx0, 2 min rx1, 3 max rx1). Write only while no word is in flight.
// Sequence: after the accepting edge come the ring update, mean, scaling, product,
//   check, 15 divider steps for the percentage and the final load, which raises out_valid.
//   An empty span, a level under the floor or a saturated result skips the divider.
// Flow: one word at a time; in_ready rises together with out_valid, so a new word
//   is taken only after the last one has reached the output register.
// Reset: rst (synchronous) clears both rings, sums and slots, sets the floors to 0 and
//   the ceilings to all ones, and empties the output register; in_ready is high at once.
// Stall: hold a result in the output register while out_ready is low; the next word
//   is still accepted and computed and waits in its final load step, and further
//   words are held off until that load.
`timescale 1ns / 1ps
`include "rssi_average_percent_defines.svh"

module rssi_average_percent #(
  parameter int FILTER_DEPTH = rssiap_pkg::FILTER_DEPTH_DEF,
  parameter int SAMPLE_BITS  = rssiap_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [SAMPLE_BITS-1:0]                level_sample,
  input  logic                                  receiver_sel,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [rssiap_pkg::PCT_W-1:0]          percent_q8,
  output logic [SAMPLE_BITS-1:0]                filtered_level,
  output logic                                  receiver_tag,
  input  logic                                  cfg_we,
  input  logic [rssiap_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [SAMPLE_BITS-1:0]                cfg_data
);

  rssiap_pkg::cmd_t    cmd;
  rssiap_pkg::status_t status;

  // Sequencer: walks capture, ring update, mean, scaling, product, check, percentage and output load steps
  rssiap_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // Datapath: holds calibration, rings, divider and the output register
  rssiap_datapath #(
    .FILTER_DEPTH (FILTER_DEPTH),
    .SAMPLE_BITS  (SAMPLE_BITS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .level_sample   (level_sample),
    .receiver_sel   (receiver_sel),
    .out_ready      (out_ready),
    .out_valid      (out_valid),
    .percent_q8     (percent_q8),
    .filtered_level (filtered_level),
    .receiver_tag   (receiver_tag)
  );

  // Checks
  logic [1:0] div_cmds;
  logic       pct_ok;
  assign div_cmds = {cmd.load_pct, cmd.div_step};
  assign pct_ok   = (percent_q8 <= rssiap_pkg::PCT_LIMIT_Q8);

  // Hold off new words while one is in flight
  `RSSIAP_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "accepted while busy")
  // Never drive a percentage above the clamp
  `RSSIAP_ASSERT_NOW(a_pct_clamped, out_valid, pct_ok, "percentage above clamp")
  // Divider is loaded or stepped, never both at once
  `RSSIAP_ASSERT_NOW(a_div_cmd_excl, 1'b1, $onehot0(div_cmds), "conflicting divider commands")
  // Load the output register only when it can take a word
  `RSSIAP_ASSERT_NOW(a_out_load_free, cmd.load_out, status.out_free, "output register overrun")

endmodule
